@@ rtl/kced_pkg.sv @@
package kced_pkg;

	// Number of keys watched; the key_levels field carries KEY_SLOTS of them.
	localparam int NUM_KEYS  = 4;
	localparam int KEY_SLOTS = 4;
	localparam int KEY_IDX_W = 2;

	localparam int FLAG_W  = 7;
	localparam int TIMER_W = 16;
	localparam int DIV_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Flag bit positions.
	localparam int F_HOLD   = 0;
	localparam int F_DOWN   = 1;
	localparam int F_UP     = 2;
	localparam int F_SINGLE = 3;
	localparam int F_DOUBLE = 4;
	localparam int F_LONG   = 5;
	localparam int F_REPEAT = 6;

	localparam logic [FLAG_W-1:0] HOLD_MASK = FLAG_W'(1) << F_HOLD;

	localparam logic [DIV_W-1:0]   DIVIDER_RST = 8'd20;
	localparam logic [TIMER_W-1:0] DOUBLE_RST  = 16'd200;
	localparam logic [TIMER_W-1:0] LONG_RST    = 16'd2000;
	localparam logic [TIMER_W-1:0] REPEAT_RST  = 16'd100;

	typedef enum logic {
		ACT_TICK  = 1'b0,
		ACT_CHECK = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIVIDER = 2'd0,
		CFG_DOUBLE  = 2'd1,
		CFG_LONG    = 2'd2,
		CFG_REPEAT  = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_PRESSED = 5'b00010,
		ST_WAIT    = 5'b00100,
		ST_SECOND  = 5'b01000,
		ST_REPEAT  = 5'b10000
	} key_state_t;

	typedef struct packed {
		logic [TIMER_W-1:0] double_window;
		logic [TIMER_W-1:0] long_time;
		logic [TIMER_W-1:0] repeat_time;
	} timer_cfg_t;

	// Per-key control for one accepted word.
	typedef struct packed {
		logic              tick;
		logic              sample;
		logic              check;
		logic [FLAG_W-1:0] sel;
	} lane_ctl_t;

endpackage

@@ rtl/key_click_event_detector.sv @@
// Channel  | handshake            | word
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | action, key_levels, key_index, flag_select
// out      | out_valid / out_stall| hit, flags_seen (one per check, none per tick)
// cfg      | cfg_we               | cfg_index, cfg_data
//
// While in_stall is low, one word per cycle is accepted; all lanes update in that cycle.
// A check result is on out in the cycle after it is accepted when the output register
// is free or empties in that cycle; behind a stalled word it waits in the skid entry.
// Output register plus one skid entry: in_stall rises only when both hold words.
// Asynchronous reset clears the timers, click machines, flags and divider count.
module key_click_event_detector
	import kced_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [KEY_SLOTS-1:0]  key_levels,
	input  logic [KEY_IDX_W-1:0]  key_index,
	input  logic [FLAG_W-1:0]     flag_select,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [FLAG_W-1:0]     flags_seen,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DIV_W-1:0]   divider_q;
	timer_cfg_t         tcfg_q;
	logic [DIV_W-1:0]   tick_count_q, tick_inc;
	logic               in_acc, do_tick, do_check, do_sample, full;
	logic [FLAG_W-1:0]  lane_flags [NUM_KEYS];
	logic [FLAG_W-1:0]  slot_flags [KEY_SLOTS];

	assign in_stall  = full;
	assign in_acc    = in_valid && !in_stall;
	assign do_tick   = in_acc && (action == ACT_TICK);
	assign do_check  = in_acc && (action == ACT_CHECK);
	assign tick_inc  = tick_count_q + DIV_W'(1);
	assign do_sample = do_tick && (tick_inc >= divider_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q            <= DIVIDER_RST;
			tcfg_q.double_window <= DOUBLE_RST;
			tcfg_q.long_time     <= LONG_RST;
			tcfg_q.repeat_time   <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DIVIDER: divider_q            <= cfg_data[DIV_W-1:0];
				CFG_DOUBLE:  tcfg_q.double_window <= cfg_data[TIMER_W-1:0];
				CFG_LONG:    tcfg_q.long_time     <= cfg_data[TIMER_W-1:0];
				CFG_REPEAT:  tcfg_q.repeat_time   <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (do_tick) begin
			tick_count_q <= do_sample ? '0 : tick_inc;
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		lane_ctl_t ctl;
		logic      pressed;

		if (k < KEY_SLOTS) begin : g_in
			assign pressed   = key_levels[k];
			assign ctl.check = do_check && (key_index == KEY_IDX_W'(k));
		end else begin : g_out
			// Keys past the input field never press and cannot be addressed.
			assign pressed   = 1'b0;
			assign ctl.check = 1'b0;
		end
		assign ctl.tick   = do_tick;
		assign ctl.sample = do_sample;
		assign ctl.sel    = flag_select;

		kced_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.pressed (pressed),
			.tcfg    (tcfg_q),
			.flags   (lane_flags[k])
		);
	end

	// A key index with no lane reads as all flags clear.
	for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_slot
		if (s < NUM_KEYS) begin : g_used
			assign slot_flags[s] = lane_flags[s];
		end else begin : g_empty
			assign slot_flags[s] = '0;
		end
	end

	kced_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_flags (slot_flags),
		.check      (do_check),
		.key_index  (key_index),
		.sel        (flag_select),
		.out_stall  (out_stall),
		.full       (full),
		.out_valid  (out_valid),
		.hit        (hit),
		.flags_seen (flags_seen)
	);

	// A stalled-in condition means the output register is holding a word.
	a_full_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry held while output empty");

	// A tick never yields a result word.
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && !out_valid) |=> !out_valid)
		else $error("tick produced a result");

	// A check into an empty output shows up next cycle with a consistent hit.
	a_check_result: assert property (@(posedge clk) disable iff (!arst_n)
		(do_check && !out_valid) |=>
		(out_valid && (hit == ((flags_seen & $past(flag_select)) != '0))))
		else $error("check result missing or inconsistent");

	// A sample resets the divider count.
	a_divider_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		do_sample |=> (tick_count_q == '0))
		else $error("divider did not restart after a sample");

endmodule

@@ rtl/kced_lane.sv @@
module kced_lane
	import kced_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic              pressed,
	input  timer_cfg_t        tcfg,
	output logic [FLAG_W-1:0] flags
);

	key_state_t         state_q, state_d;
	logic [TIMER_W-1:0] cd_q, cd_d, cd_dec;
	logic [FLAG_W-1:0]  flags_q, flags_d;
	logic               level_q, level_d;

	always_comb begin
		cd_dec  = (cd_q != '0) ? cd_q - TIMER_W'(1) : cd_q;
		cd_d    = cd_q;
		state_d = state_q;
		flags_d = flags_q;
		level_d = level_q;
		if (ctl.tick) begin
			cd_d = cd_dec;
			if (ctl.sample) begin
				level_d = pressed;
				flags_d[F_HOLD] = pressed;
				if (pressed && !level_q) begin
					flags_d[F_DOWN] = 1'b1;
				end
				if (!pressed && level_q) begin
					flags_d[F_UP] = 1'b1;
				end
				// The machine sees the timer after this tick's decrement.
				unique case (state_q)
					ST_IDLE: begin
						if (pressed) begin
							cd_d    = tcfg.long_time;
							state_d = ST_PRESSED;
						end
					end
					ST_PRESSED: begin
						if (!pressed) begin
							cd_d    = tcfg.double_window;
							state_d = ST_WAIT;
						end else if (cd_dec == '0) begin
							cd_d    = tcfg.repeat_time;
							flags_d[F_LONG] = 1'b1;
							state_d = ST_REPEAT;
						end
					end
					ST_WAIT: begin
						if (pressed) begin
							flags_d[F_DOUBLE] = 1'b1;
							state_d = ST_SECOND;
						end else if (cd_dec == '0) begin
							flags_d[F_SINGLE] = 1'b1;
							state_d = ST_IDLE;
						end
					end
					ST_SECOND: begin
						if (!pressed) begin
							state_d = ST_IDLE;
						end
					end
					ST_REPEAT: begin
						if (!pressed) begin
							state_d = ST_IDLE;
						end else if (cd_dec == '0) begin
							cd_d = tcfg.repeat_time;
							flags_d[F_REPEAT] = 1'b1;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end else if (ctl.check && ((flags_q & ctl.sel) != '0) && (ctl.sel != HOLD_MASK)) begin
			// A check of the hold bit alone only peeks.
			flags_d = flags_q & ~ctl.sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cd_q    <= '0;
			flags_q <= '0;
			level_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cd_q    <= cd_d;
			flags_q <= flags_d;
			level_q <= level_d;
		end
	end

	assign flags = flags_q;

endmodule

@@ rtl/kced_merge.sv @@
module kced_merge
	import kced_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [FLAG_W-1:0]    lane_flags [KEY_SLOTS],
	input  logic                 check,
	input  logic [KEY_IDX_W-1:0] key_index,
	input  logic [FLAG_W-1:0]    sel,
	input  logic                 out_stall,
	output logic                 full,
	output logic                 out_valid,
	output logic                 hit,
	output logic [FLAG_W-1:0]    flags_seen
);

	logic [FLAG_W-1:0] seen;
	logic              new_hit;
	logic              out_valid_q, skid_valid_q;
	logic              out_hit_q, skid_hit_q;
	logic [FLAG_W-1:0] out_flags_q, skid_flags_q;
	logic              out_fire;

	assign seen     = lane_flags[key_index];
	assign new_hit  = (seen & sel) != '0;
	assign out_fire = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (check) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_hit_q   <= skid_hit_q;
				out_flags_q <= skid_flags_q;
			end
		end else if (check) begin
			if (!out_valid_q || out_fire) begin
				out_hit_q   <= new_hit;
				out_flags_q <= seen;
			end else begin
				skid_hit_q   <= new_hit;
				skid_flags_q <= seen;
			end
		end
	end

	assign full       = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign flags_seen = out_flags_q;

endmodule
